>>> design/rmst_pkg.sv
// rmst_pkg: shared types, constants and helpers for the range-minimum segment tree
// used by range_min_segment_tree_core; no dependencies
`timescale 1ns / 1ps

package rmst_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int VAL_W        = 32;
  localparam int SLOT_W       = IDX_W + 1;
  localparam int NODE_DEPTH   = 2 * MAX_ELEMENTS;
  // one saved frame per internal tree level, plus one spare
  localparam int STACK_DEPTH  = IDX_W + 1;
  localparam int STK_AW       = $clog2(STACK_DEPTH);
  localparam int SP_W         = $clog2(STACK_DEPTH + 1);
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  localparam logic [CFG_AW-1:0] ADDR_LAST_INDEX = 3'd0;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] QS_FOUND     = 2'd0;
  localparam logic [1:0] QS_EMPTY     = 2'd1;
  localparam logic [1:0] QS_NOT_BUILT = 2'd2;

  localparam logic [VAL_W-1:0] SENTINEL = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_VISIT,
    S_READ,
    S_RET
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic             right_pending;
    logic [VAL_W-1:0] lval;
  } frame_t;

  function automatic logic [VAL_W-1:0] smin(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

  function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] l,
                                              input logic [IDX_W-1:0] r);
    logic [SLOT_W-1:0] sum;
    sum = {1'b0, l} + {1'b0, r};
    return sum[SLOT_W-1:1];
  endfunction

  // leaf [l,l] sits at 2*l, internal [l,r] at (l+r)|1
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] l,
                                                input logic [IDX_W-1:0] r);
    logic [SLOT_W-1:0] sum;
    sum = {1'b0, l} + {1'b0, r};
    return (l == r) ? {l, 1'b0} : {sum[SLOT_W-1:1], 1'b1};
  endfunction

endpackage

>>> design/rmst_ram.sv
// rmst_ram: generic simple dual-port RAM, one write and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/range_min_segment_tree_core.sv
// range_min_segment_tree_core: segment tree range-minimum engine with a stack sequencer
// depends on rmst_pkg and rmst_ram (element store and node store)
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | cmd, element_index, element_value, range_low/high
//  out_    | output    | out_valid/out_stall| min_value, query_status
//  apb     | input     | psel/penable/pready| paddr, pwdata, pwrite, prdata (last_index)
//
// after reset the element store is zeroed, one entry a cycle, with in_stall high until it is done.
// load and unused commands complete in S_IDLE. a build walks [0,last_index] depth-first, writing
// each leaf in S_READ and each inner node in S_RET through one node-store write port.
// a query skips a node outside the range, reads the stored minimum of a covered node and splits
// any other node; early-out queries (not built or empty range) go straight to S_RET.
// a finished result waits in the output register; a query held behind it stalls at its end.

module range_min_segment_tree_core
  import rmst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input transaction
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [IDX_W-1:0]         in_element_index,
  input  logic signed [VAL_W-1:0]  in_element_value,
  input  logic [IDX_W-1:0]         in_range_low,
  input  logic [IDX_W-1:0]         in_range_high,
  // result transaction
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_min_value,
  output logic [1:0]               out_query_status,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   last_index_r, last_index_nxt;
  logic [IDX_W-1:0]   built_last_r, built_last_nxt;
  logic               built_r, built_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic               is_query_r, is_query_nxt;
  logic [IDX_W-1:0]   cur_l_r, cur_l_nxt;
  logic [IDX_W-1:0]   cur_r_r, cur_r_nxt;
  logic [IDX_W-1:0]   qlo_r, qlo_nxt;
  logic [IDX_W-1:0]   qhi_r, qhi_nxt;
  logic [VAL_W-1:0]   ret_r, ret_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  frame_t             stack_r [STACK_DEPTH];
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_min_r, out_min_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               stk_we;
  logic [STK_AW-1:0]  stk_wa;
  frame_t             stk_wd;
  frame_t             top;
  logic [SP_W-1:0]    sp_dec;

  logic               elem_we;
  logic [IDX_W-1:0]   elem_waddr;
  logic [VAL_W-1:0]   elem_wdata;
  logic [VAL_W-1:0]   elem_rdata;
  logic               node_we;
  logic [SLOT_W-1:0]  node_waddr;
  logic [VAL_W-1:0]   node_wdata;
  logic [SLOT_W-1:0]  node_raddr;
  logic [VAL_W-1:0]   node_rdata;

  logic               in_acc;
  logic               cfg_wr;
  logic [VAL_W-1:0]   comb_v;
  logic [VAL_W-1:0]   leaf_v;

  rmst_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (cur_l_r),
    .rdata (elem_rdata)
  );

  rmst_ram #(.WIDTH(VAL_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  assign in_stall         = (state_r != S_IDLE);
  assign in_acc           = in_valid && !in_stall;
  assign out_valid        = out_valid_r;
  assign out_min_value    = $signed(out_min_r);
  assign out_query_status = out_status_r;
  assign pready           = 1'b1;
  assign cfg_wr           = psel && penable && pwrite;
  assign prdata = (paddr == ADDR_LAST_INDEX) ? {{(CFG_DW-IDX_W){1'b0}}, last_index_r}
                                             : '0;

  assign sp_dec     = sp_r - 1'b1;
  assign top        = stack_r[sp_dec[STK_AW-1:0]];
  assign node_raddr = slot_of(cur_l_r, cur_r_r);
  assign comb_v     = smin(top.lval, ret_r);
  assign leaf_v     = is_query_r ? node_rdata : elem_rdata;

  always_comb begin
    state_nxt      = state_r;
    last_index_nxt = last_index_r;
    built_last_nxt = built_last_r;
    built_nxt      = built_r;
    clr_cnt_nxt    = clr_cnt_r;
    is_query_nxt   = is_query_r;
    cur_l_nxt      = cur_l_r;
    cur_r_nxt      = cur_r_r;
    qlo_nxt        = qlo_r;
    qhi_nxt        = qhi_r;
    ret_nxt        = ret_r;
    status_nxt     = status_r;
    sp_nxt         = sp_r;
    out_valid_nxt  = out_valid_r;
    out_min_nxt    = out_min_r;
    out_status_nxt = out_status_r;
    stk_we         = 1'b0;
    stk_wa         = sp_r[STK_AW-1:0];
    stk_wd         = top;
    elem_we        = 1'b0;
    elem_waddr     = in_element_index;
    elem_wdata     = in_element_value;
    node_we        = 1'b0;
    node_waddr     = {cur_l_r, 1'b0};
    node_wdata     = leaf_v;

    if (cfg_wr && paddr == ADDR_LAST_INDEX) begin
      last_index_nxt = pwdata[IDX_W-1:0];
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        elem_we     = 1'b1;
        elem_waddr  = clr_cnt_r;
        elem_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(MAX_ELEMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          sp_nxt = '0;
          case (in_cmd)
            CMD_LOAD: begin
              elem_we = 1'b1;
            end
            CMD_BUILD: begin
              is_query_nxt   = 1'b0;
              built_last_nxt = last_index_r;
              cur_l_nxt      = '0;
              cur_r_nxt      = last_index_r;
              state_nxt      = S_VISIT;
            end
            CMD_QUERY: begin
              is_query_nxt = 1'b1;
              ret_nxt      = SENTINEL;
              if (!built_r) begin
                status_nxt = QS_NOT_BUILT;
                state_nxt  = S_RET;
              end else if (in_range_low > in_range_high || in_range_low > built_last_r) begin
                status_nxt = QS_EMPTY;
                state_nxt  = S_RET;
              end else begin
                status_nxt = QS_FOUND;
                qlo_nxt    = in_range_low;
                qhi_nxt    = (in_range_high > built_last_r) ? built_last_r : in_range_high;
                cur_l_nxt  = '0;
                cur_r_nxt  = built_last_r;
                state_nxt  = S_VISIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_VISIT: begin
        if (is_query_r && (qhi_r < cur_l_r || qlo_r > cur_r_r)) begin
          ret_nxt   = SENTINEL;
          state_nxt = S_RET;
        end else if ((is_query_r && qlo_r <= cur_l_r && cur_r_r <= qhi_r) ||
                     (!is_query_r && cur_l_r == cur_r_r)) begin
          // read address is already on the ram ports this cycle
          state_nxt = S_READ;
        end else begin
          stk_we    = 1'b1;
          stk_wa    = sp_r[STK_AW-1:0];
          stk_wd    = '{lo: cur_l_r, hi: cur_r_r, right_pending: 1'b0, lval: '0};
          sp_nxt    = sp_r + 1'b1;
          cur_r_nxt = mid_of(cur_l_r, cur_r_r);
        end
      end
      S_READ: begin
        ret_nxt = leaf_v;
        if (!is_query_r) begin
          node_we = 1'b1;
        end
        state_nxt = S_RET;
      end
      S_RET: begin
        if (sp_r == '0) begin
          if (is_query_r) begin
            if (!out_valid_r || !out_stall) begin
              out_valid_nxt  = 1'b1;
              out_min_nxt    = ret_r;
              out_status_nxt = status_r;
              state_nxt      = S_IDLE;
            end
          end else begin
            built_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!top.right_pending) begin
          // left child done: park its minimum and descend right
          stk_we               = 1'b1;
          stk_wa               = sp_dec[STK_AW-1:0];
          stk_wd.right_pending = 1'b1;
          stk_wd.lval          = ret_r;
          cur_l_nxt            = mid_of(top.lo, top.hi) + 1'b1;
          cur_r_nxt            = top.hi;
          state_nxt            = S_VISIT;
        end else begin
          ret_nxt = comb_v;
          sp_nxt  = sp_dec;
          if (!is_query_r) begin
            node_we    = 1'b1;
            node_waddr = slot_of(top.lo, top.hi);
            node_wdata = comb_v;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      last_index_r <= '0;
      built_last_r <= '0;
      built_r      <= 1'b0;
      clr_cnt_r    <= '0;
      sp_r         <= '0;
      is_query_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_index_r <= last_index_nxt;
      built_last_r <= built_last_nxt;
      built_r      <= built_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      sp_r         <= sp_nxt;
      is_query_r   <= is_query_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_l_r      <= cur_l_nxt;
    cur_r_r      <= cur_r_nxt;
    qlo_r        <= qlo_nxt;
    qhi_r        <= qhi_nxt;
    ret_r        <= ret_nxt;
    status_r     <= status_nxt;
    out_min_r    <= out_min_nxt;
    out_status_r <= out_status_nxt;
    if (stk_we) begin
      stack_r[stk_wa] <= stk_wd;
    end
  end

endmodule
